// File: design/lemx_pkg.sv
`default_nettype none
package lemx_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
    localparam int CELL_AW    = $clog2(CELLS);
    localparam int COORD_W    = 6;
    localparam int DIM_W      = 7;
    localparam int TAG_W      = 12;
    localparam int DIR_W      = 3;
    localparam int CLAIM_W    = 4;
    localparam int MARK_W     = 2;
    localparam int CNT_W      = 13;

    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_STEP = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    // configuration register indexes
    localparam logic [0:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [0:0] REG_GRID_HEIGHT = 1'b1;

    // wanted move, clockwise from north
    localparam logic [DIR_W-1:0] DIR_N  = 3'd0;
    localparam logic [DIR_W-1:0] DIR_NE = 3'd1;
    localparam logic [DIR_W-1:0] DIR_E  = 3'd2;
    localparam logic [DIR_W-1:0] DIR_SE = 3'd3;
    localparam logic [DIR_W-1:0] DIR_S  = 3'd4;
    localparam logic [DIR_W-1:0] DIR_SW = 3'd5;
    localparam logic [DIR_W-1:0] DIR_W_ = 3'd6;
    localparam logic [DIR_W-1:0] DIR_NW = 3'd7;

    localparam logic [MARK_W-1:0] MARK_NONE    = 2'd0;
    localparam logic [MARK_W-1:0] MARK_ARRIVED = 2'd1;
    localparam logic [MARK_W-1:0] MARK_BLOCKED = 2'd2;

    localparam logic [CLAIM_W-1:0] CLAIM_MAX = 4'hF;

    typedef struct packed {
        logic              occ;
        logic [TAG_W-1:0]  tag;
        logic [DIR_W-1:0]  dir;
    } cell_t;

    typedef enum logic [12:0] {
        ST_CLEAR  = 13'h0001,
        ST_IDLE   = 13'h0002,
        ST_RDW    = 13'h0004,
        ST_SWEEP  = 13'h0008,
        ST_C_RD   = 13'h0010,
        ST_C_TGT  = 13'h0020,
        ST_C_BMP1 = 13'h0040,
        ST_C_RDT  = 13'h0080,
        ST_C_BMP2 = 13'h0100,
        ST_D_RD   = 13'h0200,
        ST_D_TGT  = 13'h0400,
        ST_D_RDT  = 13'h0800,
        ST_D_DEC  = 13'h1000
    } state_t;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > maxv)
            r = maxv;
        return r;
    endfunction

endpackage
`default_nettype wire

// File: design/lattice_exclusion_move_step_core.sv
`default_nettype none
// channel | dir | bits                                           | accepted when
// s_      | in  | tuser kind; tdata cell_index,occ,tag,direction | s_tvalid & s_tready
// m_      | out | tuser is_step_summary; tdata read/summary     | m_tvalid & m_tready
// cfg_    | in  | index 0 grid_width, 1 grid_height              | cfg_we
// after reset a clearing pass over every cell empties the grid; no beat taken meanwhile
// load: written as the beat is accepted; read: the memory read register, then the result register
// step: mark/claim clear over every cell, then a claim walk and a decide walk over the grid,
//   each paced by the one read port of the claim memory
// s_tready is low while a result waits on m_ or a step is running
module lattice_exclusion_move_step_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // cell_index[11:0] occupied[12] tag[24:13] dir[27:25]
    input  wire logic [1:0]  s_tuser,   // kind[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // occ[0] tag[12:1] arrived[13] blocked[14]
                                        // moved[27:15] collided[40:28]
    output logic [0:0]       m_tuser,   // is_step_summary[0]
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [6:0]  cfg_wdata
);

    localparam int AW = lemx_pkg::CELL_AW;
    localparam int CW = lemx_pkg::COORD_W;
    localparam int DW = lemx_pkg::DIM_W;
    localparam int NW = lemx_pkg::CNT_W;

    lemx_pkg::state_t state_reg, state_next;

    logic [DW-1:0] width_reg, height_reg, w_eff, h_eff;
    logic [NW-1:0] n_cells;

    logic [AW-1:0] sweep_reg, sweep_next;
    logic [AW-1:0] c_reg, c_next;
    logic [CW-1:0] x_reg, x_next, y_reg, y_next;
    logic [AW-1:0] t_reg, t_next;
    logic [NW-1:0] moved_reg, moved_next, coll_reg, coll_next;
    logic          ok_reg, ok_next;
    logic          rd_in_reg, rd_in_next;
    lemx_pkg::cell_t cur_reg, cur_next;

    logic          m_valid_reg, m_valid_next;
    logic [47:0]   m_data_reg, m_data_next;
    logic          m_user_reg, m_user_next;

    // ram ports
    logic              cell_we, mark_we, claim_we;
    logic [AW-1:0]     cell_wa, mark_wa, claim_wa, cell_ra, mark_ra, claim_ra;
    lemx_pkg::cell_t   cell_wd, cell_rd;
    logic [lemx_pkg::MARK_W-1:0]  mark_wd, mark_rd;
    logic [lemx_pkg::CLAIM_W-1:0] claim_wd, claim_rd, claim_inc;

    logic [AW-1:0] target;
    logic          tgt_load;

    logic [1:0]    in_kind;
    logic [AW-1:0] in_idx;
    logic          in_fire, in_range, last_cell;
    lemx_pkg::cell_t in_cell;

    // config registers and effective grid size
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DW'(lemx_pkg::MAX_WIDTH);
            height_reg <= DW'(lemx_pkg::MAX_HEIGHT);
        end else if (cfg_we) begin
            if (cfg_index == lemx_pkg::REG_GRID_WIDTH)
                width_reg <= cfg_wdata;
            else
                height_reg <= cfg_wdata;
        end
    end

    assign w_eff   = lemx_pkg::eff_dim(width_reg, DW'(lemx_pkg::MAX_WIDTH));
    assign h_eff   = lemx_pkg::eff_dim(height_reg, DW'(lemx_pkg::MAX_HEIGHT));
    assign n_cells = NW'(w_eff * h_eff);

    assign in_kind = s_tuser;
    assign in_idx  = s_tdata[11:0];
    assign in_cell = '{occ: s_tdata[12], tag: s_tdata[24:13], dir: s_tdata[27:25]};
    assign in_range = {1'b0, in_idx} < n_cells;
    assign s_tready = (state_reg == lemx_pkg::ST_IDLE) && !m_valid_reg;
    assign in_fire  = s_tvalid && s_tready;

    assign last_cell = ({1'b0, x_reg} == w_eff - 7'd1) && ({1'b0, y_reg} == h_eff - 7'd1);
    assign claim_inc = (claim_rd == lemx_pkg::CLAIM_MAX) ? claim_rd : claim_rd + 4'd1;
    assign tgt_load  = (state_reg == lemx_pkg::ST_C_TGT) || (state_reg == lemx_pkg::ST_D_TGT);

    lemx_target u_target (
        .aclk   (aclk),
        .load   (tgt_load),
        .x      (x_reg),
        .y      (y_reg),
        .dir    (cell_rd.dir),
        .w      (w_eff),
        .h      (h_eff),
        .target (target)
    );

    lemx_ram #(.WIDTH($bits(lemx_pkg::cell_t)), .DEPTH(lemx_pkg::CELLS)) u_cell_ram (
        .aclk(aclk), .we(cell_we), .waddr(cell_wa), .wdata(cell_wd),
        .raddr(cell_ra), .rdata(cell_rd)
    );

    lemx_ram #(.WIDTH(lemx_pkg::MARK_W), .DEPTH(lemx_pkg::CELLS)) u_mark_ram (
        .aclk(aclk), .we(mark_we), .waddr(mark_wa), .wdata(mark_wd),
        .raddr(mark_ra), .rdata(mark_rd)
    );

    lemx_ram #(.WIDTH(lemx_pkg::CLAIM_W), .DEPTH(lemx_pkg::CELLS)) u_claim_ram (
        .aclk(aclk), .we(claim_we), .waddr(claim_wa), .wdata(claim_wd),
        .raddr(claim_ra), .rdata(claim_rd)
    );

    // sequencer
    always_comb begin
        state_next   = state_reg;
        sweep_next   = sweep_reg;
        c_next       = c_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        t_next       = t_reg;
        moved_next   = moved_reg;
        coll_next    = coll_reg;
        ok_next      = ok_reg;
        rd_in_next   = rd_in_reg;
        cur_next     = cur_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;

        cell_we  = 1'b0;
        cell_wa  = c_reg;
        cell_wd  = '0;
        mark_we  = 1'b0;
        mark_wa  = c_reg;
        mark_wd  = lemx_pkg::MARK_NONE;
        claim_we = 1'b0;
        claim_wa = c_reg;
        claim_wd = '0;
        cell_ra  = c_reg;
        mark_ra  = c_reg;
        claim_ra = c_reg;

        unique case (state_reg)
            lemx_pkg::ST_CLEAR: begin
                cell_we  = 1'b1;
                cell_wa  = sweep_reg;
                mark_we  = 1'b1;
                mark_wa  = sweep_reg;
                claim_we = 1'b1;
                claim_wa = sweep_reg;
                sweep_next = sweep_reg + 1'b1;
                if (&sweep_reg)
                    state_next = lemx_pkg::ST_IDLE;
            end
            lemx_pkg::ST_IDLE: begin
                cell_ra = in_idx;
                mark_ra = in_idx;
                if (in_fire) begin
                    unique case (in_kind)
                        lemx_pkg::KIND_LOAD: begin
                            if (in_range) begin
                                cell_we = 1'b1;
                                cell_wa = in_idx;
                                cell_wd = in_cell;
                                mark_we = 1'b1;
                                mark_wa = in_idx;
                            end
                        end
                        lemx_pkg::KIND_STEP: begin
                            sweep_next = '0;
                            moved_next = '0;
                            coll_next  = '0;
                            state_next = lemx_pkg::ST_SWEEP;
                        end
                        lemx_pkg::KIND_READ: begin
                            rd_in_next = in_range;
                            state_next = lemx_pkg::ST_RDW;
                        end
                        default: ;
                    endcase
                end
            end
            lemx_pkg::ST_RDW: begin
                m_valid_next = 1'b1;
                m_user_next  = 1'b0;
                m_data_next  = '0;
                if (rd_in_reg && cell_rd.occ) begin
                    m_data_next[0]    = 1'b1;
                    m_data_next[12:1] = cell_rd.tag;
                    m_data_next[13]   = mark_rd[0];
                    m_data_next[14]   = mark_rd[1];
                end
                state_next = lemx_pkg::ST_IDLE;
            end
            lemx_pkg::ST_SWEEP: begin
                // marks and claims of every cell start from zero
                mark_we  = 1'b1;
                mark_wa  = sweep_reg;
                claim_we = 1'b1;
                claim_wa = sweep_reg;
                sweep_next = sweep_reg + 1'b1;
                if (&sweep_reg) begin
                    c_next = '0;
                    x_next = '0;
                    y_next = '0;
                    state_next = lemx_pkg::ST_C_RD;
                end
            end
            lemx_pkg::ST_C_RD: begin
                state_next = lemx_pkg::ST_C_TGT;
            end
            lemx_pkg::ST_C_TGT: begin
                if (cell_rd.occ)
                    state_next = lemx_pkg::ST_C_BMP1;
                else if (last_cell) begin
                    c_next = '0;
                    x_next = '0;
                    y_next = '0;
                    state_next = lemx_pkg::ST_D_RD;
                end else begin
                    c_next = c_reg + 1'b1;
                    if ({1'b0, x_reg} == w_eff - 7'd1) begin
                        x_next = '0;
                        y_next = y_reg + 1'b1;
                    end else
                        x_next = x_reg + 1'b1;
                    state_next = lemx_pkg::ST_C_RD;
                end
            end
            lemx_pkg::ST_C_BMP1: begin
                claim_we = 1'b1;
                claim_wd = claim_inc;
                t_next   = target;
                state_next = lemx_pkg::ST_C_RDT;
            end
            lemx_pkg::ST_C_RDT: begin
                claim_ra = t_reg;
                state_next = lemx_pkg::ST_C_BMP2;
            end
            lemx_pkg::ST_C_BMP2: begin
                claim_we = 1'b1;
                claim_wa = t_reg;
                claim_wd = claim_inc;
                if (last_cell) begin
                    c_next = '0;
                    x_next = '0;
                    y_next = '0;
                    state_next = lemx_pkg::ST_D_RD;
                end else begin
                    c_next = c_reg + 1'b1;
                    if ({1'b0, x_reg} == w_eff - 7'd1) begin
                        x_next = '0;
                        y_next = y_reg + 1'b1;
                    end else
                        x_next = x_reg + 1'b1;
                    state_next = lemx_pkg::ST_C_RD;
                end
            end
            lemx_pkg::ST_D_RD: begin
                state_next = lemx_pkg::ST_D_TGT;
            end
            lemx_pkg::ST_D_TGT: begin
                cur_next = cell_rd;
                // a particle that arrived this step has already been decided
                if (cell_rd.occ && (mark_rd != lemx_pkg::MARK_ARRIVED))
                    state_next = lemx_pkg::ST_D_RDT;
                else if (last_cell) begin
                    m_valid_next = 1'b1;
                    m_user_next  = 1'b1;
                    m_data_next  = {7'd0, coll_reg, moved_reg, 15'd0};
                    state_next   = lemx_pkg::ST_IDLE;
                end else begin
                    c_next = c_reg + 1'b1;
                    if ({1'b0, x_reg} == w_eff - 7'd1) begin
                        x_next = '0;
                        y_next = y_reg + 1'b1;
                    end else
                        x_next = x_reg + 1'b1;
                    state_next = lemx_pkg::ST_D_RD;
                end
            end
            lemx_pkg::ST_D_RDT: begin
                ok_next  = (claim_rd == 4'd1);
                t_next   = target;
                claim_ra = target;
                state_next = lemx_pkg::ST_D_DEC;
            end
            lemx_pkg::ST_D_DEC: begin
                if (ok_reg && (claim_rd == 4'd1)) begin
                    // target held only this claim, so it is empty: move in
                    cell_we = 1'b1;
                    cell_wa = t_reg;
                    cell_wd = cur_reg;
                    mark_we = 1'b1;
                    mark_wa = t_reg;
                    mark_wd = lemx_pkg::MARK_ARRIVED;
                    moved_next = moved_reg + 1'b1;
                    ok_next    = 1'b0;
                    state_next = lemx_pkg::ST_D_DEC;
                    cur_next.occ = 1'b0;
                end else begin
                    if (cur_reg.occ) begin
                        mark_we = 1'b1;
                        mark_wd = lemx_pkg::MARK_BLOCKED;
                        coll_next = coll_reg + 1'b1;
                    end else begin
                        // second visit after a move: vacate the source
                        cell_we = 1'b1;
                        cell_wd = '0;
                    end
                    if (last_cell) begin
                        m_valid_next = 1'b1;
                        m_user_next  = 1'b1;
                        m_data_next  = {7'd0, coll_next, moved_reg, 15'd0};
                        state_next   = lemx_pkg::ST_IDLE;
                    end else begin
                        c_next = c_reg + 1'b1;
                        if ({1'b0, x_reg} == w_eff - 7'd1) begin
                            x_next = '0;
                            y_next = y_reg + 1'b1;
                        end else
                            x_next = x_reg + 1'b1;
                        state_next = lemx_pkg::ST_D_RD;
                    end
                end
            end
            default: state_next = lemx_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lemx_pkg::ST_CLEAR;
            sweep_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sweep_reg   <= sweep_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        c_reg      <= c_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        t_reg      <= t_next;
        moved_reg  <= moved_next;
        coll_reg   <= coll_next;
        ok_reg     <= ok_next;
        rd_in_reg  <= rd_in_next;
        cur_reg    <= cur_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`ifndef NO_ASSERTIONS
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == lemx_pkg::ST_RDW ||
                                     state_reg == lemx_pkg::ST_D_TGT ||
                                     state_reg == lemx_pkg::ST_D_DEC))
        else $error("result raised outside a read or step end");
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> state_reg == lemx_pkg::ST_CLEAR && !m_valid_reg)
        else $error("reset does not start the clearing pass");
    a_no_move_twice: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lemx_pkg::ST_D_DEC && mark_we && mark_wd == lemx_pkg::MARK_ARRIVED)
        |=> state_reg == lemx_pkg::ST_D_DEC && !cur_reg.occ)
        else $error("mover source not vacated");
`endif

endmodule
`default_nettype wire

// File: design/lemx_ram.sv
`default_nettype none
module lemx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: design/lemx_target.sv
`default_nettype none
module lemx_target (
    input  wire logic                           aclk,
    input  wire logic                           load,
    input  wire logic [lemx_pkg::COORD_W-1:0]   x,
    input  wire logic [lemx_pkg::COORD_W-1:0]   y,
    input  wire logic [lemx_pkg::DIR_W-1:0]     dir,
    input  wire logic [lemx_pkg::DIM_W-1:0]     w,
    input  wire logic [lemx_pkg::DIM_W-1:0]     h,
    output logic      [lemx_pkg::CELL_AW-1:0]   target
);

    logic east, west, north, south;
    logic [lemx_pkg::DIM_W-1:0] xe, ye, nx, ny;
    logic [lemx_pkg::CELL_AW-1:0] t_next;

    always_comb begin
        east  = (dir == lemx_pkg::DIR_NE) || (dir == lemx_pkg::DIR_E)
             || (dir == lemx_pkg::DIR_SE);
        west  = (dir == lemx_pkg::DIR_SW) || (dir == lemx_pkg::DIR_W_)
             || (dir == lemx_pkg::DIR_NW);
        north = (dir == lemx_pkg::DIR_NW) || (dir == lemx_pkg::DIR_N)
             || (dir == lemx_pkg::DIR_NE);
        south = (dir == lemx_pkg::DIR_SE) || (dir == lemx_pkg::DIR_S)
             || (dir == lemx_pkg::DIR_SW);
        xe = {1'b0, x};
        ye = {1'b0, y};
        // wrap around the torus edges
        if (east)
            nx = (xe + 7'd1 == w) ? '0 : xe + 7'd1;
        else if (west)
            nx = (xe == '0) ? w - 7'd1 : xe - 7'd1;
        else
            nx = xe;
        if (south)
            ny = (ye + 7'd1 == h) ? '0 : ye + 7'd1;
        else if (north)
            ny = (ye == '0) ? h - 7'd1 : ye - 7'd1;
        else
            ny = ye;
        t_next = lemx_pkg::CELL_AW'(ny[lemx_pkg::COORD_W-1:0] * w)
               + lemx_pkg::CELL_AW'(nx);
    end

    always_ff @(posedge aclk) begin
        if (load)
            target <= t_next;
    end

endmodule
`default_nettype wire
